FILE: src/scld_pkg.sv
// Shared types, codes and keyword table for the serial command line decoder.
package scld_pkg;

  localparam int LINE_CHARS_DEF = 32;
  // Longest keyword; only this many leading command characters can ever match.
  localparam int KW_CHARS = 6;
  localparam int KW_COUNT = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_UNKNOWN = 4'd1;
  localparam logic [3:0] ACT_KW_BASE = 4'd2;
  localparam logic [3:0] ACT_M_ON    = 4'd10;
  localparam logic [3:0] ACT_M_OFF   = 4'd11;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ARG_PUT,
    OP_ARG_DEL,
    OP_EOL
  } op_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    op_t        op;
    logic [3:0] action;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } back_state_t;

  // Keyword text, first character in the low byte, zero padded.
  function automatic logic [8*KW_CHARS-1:0] kw_text(input int k);
    logic [8*KW_CHARS-1:0] t;
    t = '0;
    case (k)
      0: t = 48'h00_6E_6F_2D_33_6C;  // l3-on
      1: t = 48'h66_66_6F_2D_33_6C;  // l3-off
      2: t = 48'h00_6E_6F_2D_34_6C;  // l4-on
      3: t = 48'h66_66_6F_2D_34_6C;  // l4-off
      4: t = 48'h00_6E_6F_2D_35_6C;  // l5-on
      5: t = 48'h66_66_6F_2D_35_6C;  // l5-off
      6: t = 48'h00_6E_6F_2D_36_6C;  // l6-on
      7: t = 48'h66_66_6F_2D_36_6C;  // l6-off
      8: t = 48'h00_00_6E_6F_2D_6D;  // m-on
      9: t = 48'h00_66_66_6F_2D_6D;  // m-off
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] n;
    case (k)
      0, 2, 4, 6, 9: n = 3'd5;
      1, 3, 5, 7:    n = 3'd6;
      8:             n = 3'd4;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: src/scld_front.sv
// Front end: accepts bytes, edits the command word, matches keywords at end of line.
module scld_front #(
  parameter int LINE_CHARS = scld_pkg::LINE_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_rx_byte,
  input  logic            q_full,
  output logic            q_push,
  output scld_pkg::entry_t q_entry
);
  import scld_pkg::*;

  localparam int LW = $clog2(LINE_CHARS + 1);

  logic [7:0]    cmd_r  [KW_CHARS];
  logic [7:0]    cmd_nxt[KW_CHARS];
  logic [7:0]    prev_r [KW_CHARS];
  logic [7:0]    prev_nxt[KW_CHARS];
  logic [7:0]    eff    [KW_CHARS];
  logic [LW-1:0] cmd_len_r, cmd_len_nxt, prev_len_r, prev_len_nxt, eff_len;
  logic          mode_r, mode_nxt;
  logic          take, is_eol, is_space, is_del, is_prt;
  logic [3:0]    action;
  logic [8*KW_CHARS-1:0] eff_flat;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign is_eol   = (in_rx_byte == CH_LF) || (in_rx_byte == CH_CR);
  assign is_space = (in_rx_byte == CH_SPACE);
  assign is_del   = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
  assign is_prt   = (in_rx_byte > CH_SPACE) && (in_rx_byte <= CH_TILDE);

  always_comb begin
    eff_len = (cmd_len_r == '0) ? prev_len_r : cmd_len_r;
    for (int i = 0; i < KW_CHARS; i++) begin
      eff[i] = (cmd_len_r == '0) ? prev_r[i] : cmd_r[i];
      eff_flat[8*i +: 8] = eff[i];
    end
    action = ACT_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (eff_len == LW'(kw_len(k)) && eff_flat == kw_text(k)) begin
        action = ACT_KW_BASE + 4'(k);
      end
    end
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    prev_nxt     = prev_r;
    cmd_len_nxt  = cmd_len_r;
    prev_len_nxt = prev_len_r;
    mode_nxt     = mode_r;
    q_entry.rx_byte = in_rx_byte;
    q_entry.op      = OP_NONE;
    q_entry.action  = ACT_NONE;
    if (take) begin
      if (is_eol) begin
        mode_nxt     = 1'b0;
        prev_nxt     = eff;
        prev_len_nxt = eff_len;
        cmd_len_nxt  = '0;
        for (int i = 0; i < KW_CHARS; i++) cmd_nxt[i] = '0;
        q_entry.op     = OP_EOL;
        q_entry.action = action;
      end else if (is_space) begin
        mode_nxt = 1'b1;
      end else if (!mode_r) begin
        if (is_del && cmd_len_r != '0) begin
          cmd_len_nxt = cmd_len_r - LW'(1);
          for (int i = 0; i < KW_CHARS; i++) begin
            if (cmd_len_nxt == LW'(i)) cmd_nxt[i] = '0;
          end
        end else if (is_prt && cmd_len_r < LW'(LINE_CHARS)) begin
          cmd_len_nxt = cmd_len_r + LW'(1);
          for (int i = 0; i < KW_CHARS; i++) begin
            if (cmd_len_r == LW'(i)) cmd_nxt[i] = in_rx_byte;
          end
        end
      end else if (is_del) begin
        q_entry.op = OP_ARG_DEL;
      end else if (is_prt) begin
        q_entry.op = OP_ARG_PUT;
      end
    end
  end

  assign q_push = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_len_r  <= '0;
      prev_len_r <= '0;
      mode_r     <= 1'b0;
      for (int i = 0; i < KW_CHARS; i++) begin
        cmd_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      cmd_len_r  <= cmd_len_nxt;
      prev_len_r <= prev_len_nxt;
      mode_r     <= mode_nxt;
      cmd_r      <= cmd_nxt;
      prev_r     <= prev_nxt;
    end
  end

endmodule

FILE: src/scld_fifo.sv
// Short queue of classified bytes between front and back.
module scld_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  scld_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output scld_pkg::entry_t head
);
  import scld_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PW'(1);
      if (pop)  rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: src/scld_back.sv
// Back end: argument word storage, decimal conversion and the result register.
module scld_back #(
  parameter int LINE_CHARS = scld_pkg::LINE_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  scld_pkg::entry_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_echo_byte,
  output logic [3:0]         out_action,
  output logic signed [31:0] out_motor_level
);
  import scld_pkg::*;

  localparam int LW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(LINE_CHARS);
  localparam logic [31:0] MAG_LIM = 32'h8000_0000;

  back_state_t   state_r, state_nxt;
  logic [7:0]    mem [LINE_CHARS];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [LW-1:0] alen_r, alen_nxt, idx_r, idx_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    oe_r, oe_nxt;
  logic [3:0]    oa_r, oa_nxt;
  logic [31:0]   ol_r, ol_nxt;
  logic          slot_free, is_sign, is_digit;
  logic [35:0]   m10;
  logic [31:0]   level;

  assign slot_free = !ov_r || !out_stall;
  assign is_sign   = (rd_data_r == CH_PLUS) || (rd_data_r == CH_MINUS);
  assign is_digit  = (rd_data_r >= CH_ZERO) && (rd_data_r <= CH_NINE);
  assign m10       = {4'b0, mag_r} * 36'd10 + 36'(rd_data_r - CH_ZERO);
  assign level     = neg_r ? (32'd0 - mag_r) : (mag_r[31] ? 32'h7FFF_FFFF : mag_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[alen_r[AW-1:0]] <= q_head.rx_byte;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    alen_nxt  = alen_r;
    idx_nxt   = idx_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    hold_nxt  = hold_r;
    ov_nxt    = ov_r && out_stall;
    oe_nxt    = oe_r;
    oa_nxt    = oa_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.op == OP_EOL && q_head.action == ACT_M_ON) begin
            q_pop     = 1'b1;
            hold_nxt  = q_head.rx_byte;
            idx_nxt   = '0;
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
            state_nxt = BK_WALK;
          end else if (slot_free) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            oe_nxt = q_head.rx_byte;
            oa_nxt = q_head.action;
            ol_nxt = '0;
            unique case (q_head.op)
              OP_ARG_PUT: begin
                if (alen_r < LW'(LINE_CHARS)) begin
                  wr_en    = 1'b1;
                  alen_nxt = alen_r + LW'(1);
                end
              end
              OP_ARG_DEL: if (alen_r != '0) alen_nxt = alen_r - LW'(1);
              OP_EOL:     alen_nxt = '0;
              default:    ;
            endcase
          end
        end
      end
      BK_WALK: begin
        rd_addr = AW'(idx_r + LW'(1));
        if (idx_r < alen_r && idx_r == '0 && is_sign) begin
          neg_nxt = (rd_data_r == CH_MINUS);
          idx_nxt = idx_r + LW'(1);
        end else if (idx_r < alen_r && is_digit) begin
          mag_nxt = (m10 > 36'(MAG_LIM)) ? MAG_LIM : m10[31:0];
          idx_nxt = idx_r + LW'(1);
        end else begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          oe_nxt    = hold_r;
          oa_nxt    = ACT_M_ON;
          ol_nxt    = level;
          alen_nxt  = '0;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      alen_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      alen_r  <= alen_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r  <= idx_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    hold_r <= hold_nxt;
    oe_r   <= oe_nxt;
    oa_r   <= oa_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_echo_byte   = oe_r;
  assign out_action      = oa_r;
  assign out_motor_level = $signed(ol_r);

endmodule

FILE: src/serial_command_line_decoder_core.sv
// Top level of the serial command line decoder: front end, queue and back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | input     | in_valid/in_stall  | in_rx_byte[7:0]
//  out     | output    | out_valid/out_stall| out_echo_byte[7:0], out_action[3:0],
//          |           |                    | out_motor_level[31:0] signed
//
// Every byte gives one result. Editing bytes go through a queue slot and then the
// result register. An end of line that matches m-on walks the argument word in the
// back end, one stored character per cycle off the argument memory read port. The
// queue lets the front keep taking bytes while that walk runs.
// Reset is synchronous, active low; it empties the queue and clears all words.
// out_stall holds the result register and backs up the queue; in_stall rises
// only when the queue is full.
module serial_command_line_decoder_core #(
  parameter int LINE_CHARS = scld_pkg::LINE_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_echo_byte,
  output logic [3:0]         out_action,
  output logic signed [31:0] out_motor_level
);
  import scld_pkg::*;

  entry_t push_entry, head;
  logic   push, full, pop, empty;

  // Classify and edit the command word; push one entry per transfer.
  scld_front #(.LINE_CHARS(LINE_CHARS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (full),
    .q_push     (push),
    .q_entry    (push_entry)
  );

  scld_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  // Edit the argument word, convert it on m-on, and drive the result register.
  scld_back #(.LINE_CHARS(LINE_CHARS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (empty),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_echo_byte   (out_echo_byte),
    .out_action      (out_action),
    .out_motor_level (out_motor_level)
  );

endmodule

FILE: src/scld_checker.sv
// Port-level checks for the serial command line decoder, bound to the top level.
module scld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_echo_byte,
  input logic [3:0]         out_action,
  input logic signed [31:0] out_motor_level
);
  import scld_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_motor_level))
    else $error("stalled result changed");

  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_M_ON |-> out_motor_level == 32'sd0)
    else $error("motor level set without motor on");

  a_action_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_NONE |->
      (out_echo_byte == CH_LF || out_echo_byte == CH_CR))
    else $error("action on a byte that is not end of line");

  a_eol_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_echo_byte == CH_LF || out_echo_byte == CH_CR) |->
      (out_action != ACT_NONE && out_action <= ACT_M_OFF))
    else $error("end of line without a valid action");

endmodule

bind serial_command_line_decoder_core scld_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_echo_byte   (out_echo_byte),
  .out_action      (out_action),
  .out_motor_level (out_motor_level)
);
